### rtl/ltfr_pkg.sv
`default_nettype none

package ltfr_pkg;

    // Field widths.
    localparam int unsigned CntW  = 64;
    localparam int unsigned TgtW  = 8;
    localparam int unsigned LoadW = 7;
    localparam int unsigned CfgW  = 8;
    localparam int unsigned IdxW  = 2;

    // Quotient bits of the load divider and of the goal quotient. Eight covers both
    // the load quotient (below 100) and the goal quotient (at most 255).
    localparam int unsigned QuoW  = 8;

    // Dividend and shifted-divisor width: the scaled idle delta needs 64 + 7 bits.
    localparam int unsigned ProdW = CntW + LoadW;

    localparam int unsigned LoadFull = 100;

    // Reciprocal of 100 for the goal quotient: 5243 / 2^19 gives the exact floor
    // for every goal product below 25600.
    localparam int unsigned          RecipW    = 13;
    localparam logic [RecipW-1:0]    GoalRecip = 13'd5243;
    localparam int unsigned          GoalShift = 19;

    // Register indexes on the configuration port.
    localparam logic [IdxW-1:0] CfgFloor   = 2'd0;
    localparam logic [IdxW-1:0] CfgCeiling = 2'd1;
    localparam logic [IdxW-1:0] CfgRamp    = 2'd2;

    // Register reset values.
    localparam logic [CfgW-1:0] FloorRst   = 8'd80;
    localparam logic [CfgW-1:0] CeilingRst = 8'd123;
    localparam logic [CfgW-1:0] RampRst    = 8'd4;

    typedef struct packed {
        logic [CntW-1:0] idle_time;
        logic [CntW-1:0] kernel_time;
        logic [CntW-1:0] user_time;
        logic            sample_valid;
        logic [TgtW-1:0] target_readback;
        logic            reseed;
        logic            loop_active;
    } t_item;

    typedef struct packed {
        logic [TgtW-1:0]  fan_target;
        logic [LoadW-1:0] load_percent;
        logic             target_written;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic delta;
        logic scale;
        logic div_step;
        logic load_fin;
        logic goal_init;
        logic goal_div;
        logic update;
    } t_cmd;

endpackage

`default_nettype wire

### rtl/ltfr_in_if.sv
`default_nettype none

interface ltfr_in_if;
    logic                       valid;
    logic                       ready;
    logic [ltfr_pkg::CntW-1:0]  idle_time;
    logic [ltfr_pkg::CntW-1:0]  kernel_time;
    logic [ltfr_pkg::CntW-1:0]  user_time;
    logic                       sample_valid;
    logic [ltfr_pkg::TgtW-1:0]  target_readback;
    logic                       reseed;
    logic                       loop_active;

    modport source (
        output valid, idle_time, kernel_time, user_time, sample_valid,
               target_readback, reseed, loop_active,
        input  ready
    );

    modport sink (
        input  valid, idle_time, kernel_time, user_time, sample_valid,
               target_readback, reseed, loop_active,
        output ready
    );
endinterface

`default_nettype wire

### rtl/ltfr_out_if.sv
`default_nettype none

interface ltfr_out_if;
    logic                       valid;
    logic                       ready;
    logic [ltfr_pkg::TgtW-1:0]  fan_target;
    logic [ltfr_pkg::LoadW-1:0] load_percent;
    logic                       target_written;

    modport source (
        output valid, fan_target, load_percent, target_written,
        input  ready
    );

    modport sink (
        input  valid, fan_target, load_percent, target_written,
        output ready
    );
endinterface

`default_nettype wire

### rtl/ltfr_ctrl.sv
`default_nettype none

module ltfr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output ltfr_pkg::t_cmd     o_cmd
);
    import ltfr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DELTA,
        S_SCALE,
        S_DIVL,
        S_LOADFIN,
        S_GINIT,
        S_DIVG,
        S_UPD
    } t_state;

    localparam logic [2:0] StepLast = 3'(QuoW - 1);

    t_state     r_state;
    logic [2:0] r_cnt;
    logic       r_out_valid;

    always_comb begin
        o_in_ready      = (r_state == S_IDLE);
        o_cmd           = '0;
        o_cmd.capture   = i_in_valid && (r_state == S_IDLE);
        o_cmd.delta     = (r_state == S_DELTA);
        o_cmd.scale     = (r_state == S_SCALE);
        o_cmd.div_step  = (r_state == S_DIVL);
        o_cmd.load_fin  = (r_state == S_LOADFIN);
        o_cmd.goal_init = (r_state == S_GINIT);
        o_cmd.goal_div  = (r_state == S_DIVG);
        // The result register is only overwritten once it is free.
        o_cmd.update    = (r_state == S_UPD) && (!r_out_valid || i_out_ready);
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.update) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_DELTA;
                    end
                end
                S_DELTA: begin
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_cnt   <= '0;
                    r_state <= S_DIVL;
                end
                S_DIVL: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == StepLast) begin
                        r_state <= S_LOADFIN;
                    end
                end
                S_LOADFIN: begin
                    r_state <= S_GINIT;
                end
                S_GINIT: begin
                    r_state <= S_DIVG;
                end
                S_DIVG: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (o_cmd.update) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

`default_nettype wire

### rtl/ltfr_dp.sv
`default_nettype none

module ltfr_dp (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire ltfr_pkg::t_cmd             i_cmd,
    input  wire ltfr_pkg::t_item            i_item,
    input  wire logic                       i_cfg_we,
    input  wire logic [ltfr_pkg::IdxW-1:0]  i_cfg_idx,
    input  wire logic [ltfr_pkg::CfgW-1:0]  i_cfg_data,
    output ltfr_pkg::t_result               o_result
);
    import ltfr_pkg::*;

    // Configuration.
    logic [CfgW-1:0]  r_floor;
    logic [CfgW-1:0]  r_ceiling;
    logic [CfgW-1:0]  r_ramp;

    // Tracking state.
    logic [CntW-1:0]  r_last_busy;
    logic [CntW-1:0]  r_last_idle;
    logic [TgtW-1:0]  r_cur;

    // Working registers.
    t_item            r_item;
    logic [CntW-1:0]  r_busy;
    logic [CntW-1:0]  r_dbusy;
    logic [CntW-1:0]  r_didle;
    logic             r_ok;
    logic             r_go;
    logic [ProdW-1:0] r_rem;
    logic [ProdW-1:0] r_dsh;
    logic [QuoW-1:0]  r_quo;
    logic [LoadW-1:0] r_load;
    logic             r_neg;
    t_result          r_result;

    logic signed [CfgW:0]         span;
    logic [CfgW:0]                span_mag;
    logic [CfgW+LoadW-1:0]        prod;
    logic [CfgW+LoadW+RecipW-1:0] goal_scaled;
    logic signed [10:0]           goal;
    logic signed [10:0]           step;
    logic signed [10:0]           diff;
    logic signed [10:0]           next_t;
    logic [TgtW-1:0]              base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor   <= FloorRst;
            r_ceiling <= CeilingRst;
            r_ramp    <= RampRst;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CfgFloor:   r_floor   <= i_cfg_data;
                CfgCeiling: r_ceiling <= i_cfg_data;
                CfgRamp:    r_ramp    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Goal magnitude: |ceiling - floor| times load, divided by 100 afterwards
    // through a multiply by the reciprocal.
    always_comb begin
        span        = $signed({1'b0, r_ceiling}) - $signed({1'b0, r_floor});
        span_mag    = span[CfgW] ? 9'(-span) : 9'(span);
        prod        = span_mag[CfgW-1:0] * r_load;
        goal_scaled = r_rem[CfgW+LoadW-1:0] * GoalRecip;
    end

    // Final ramp step and clamps.
    always_comb begin
        if (r_neg) begin
            goal = $signed({3'b0, r_floor}) - $signed({3'b0, r_quo});
        end else begin
            goal = $signed({3'b0, r_floor}) + $signed({3'b0, r_quo});
        end
        base = (r_item.reseed || r_cur == '0) ? r_item.target_readback : r_cur;
        if (base < r_floor) begin
            base = r_floor;
        end
        step = $signed({3'b0, r_ramp});
        diff = goal - $signed({3'b0, base});
        if (diff > step) begin
            diff = step;
        end
        if (diff < -step) begin
            diff = -step;
        end
        next_t = $signed({3'b0, base}) + diff;
        if (next_t < $signed({3'b0, r_floor})) begin
            next_t = $signed({3'b0, r_floor});
        end
        if (next_t > $signed({3'b0, r_ceiling})) begin
            next_t = $signed({3'b0, r_ceiling});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_busy <= '0;
            r_last_idle <= '0;
            r_cur       <= '0;
        end else begin
            if (i_cmd.delta && r_item.loop_active && r_item.sample_valid) begin
                r_last_busy <= r_busy;
                r_last_idle <= r_item.idle_time;
            end
            if (i_cmd.update && r_item.loop_active) begin
                r_cur <= next_t[TgtW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
            r_busy <= i_item.kernel_time + i_item.user_time;
        end
        if (i_cmd.delta) begin
            r_dbusy <= r_busy - r_last_busy;
            r_didle <= (r_item.idle_time > r_last_idle) ?
                       (r_item.idle_time - r_last_idle) : '0;
            r_ok    <= r_item.sample_valid && (r_last_busy != '0) &&
                       (r_busy > r_last_busy);
        end
        if (i_cmd.scale) begin
            r_go  <= r_ok && (r_didle < r_dbusy);
            r_rem <= (ProdW'(r_didle) << 6) + (ProdW'(r_didle) << 5) +
                     (ProdW'(r_didle) << 2);
            r_dsh <= ProdW'(r_dbusy) << (QuoW - 1);
            r_quo <= '0;
        end
        if (i_cmd.div_step) begin
            if (r_rem >= r_dsh) begin
                r_rem <= r_rem - r_dsh;
                r_quo <= {r_quo[QuoW-2:0], 1'b1};
            end else begin
                r_quo <= {r_quo[QuoW-2:0], 1'b0};
            end
            r_dsh <= r_dsh >> 1;
        end
        if (i_cmd.load_fin) begin
            r_load <= r_go ? (LoadW'(LoadFull) - r_quo[LoadW-1:0]) : '0;
        end
        if (i_cmd.goal_init) begin
            r_neg <= span[CfgW];
            r_rem <= ProdW'(prod);
        end
        if (i_cmd.goal_div) begin
            r_quo <= goal_scaled[GoalShift +: QuoW];
        end
        if (i_cmd.update) begin
            if (r_item.loop_active) begin
                r_result.fan_target   <= next_t[TgtW-1:0];
                r_result.load_percent <= r_load;
            end else begin
                r_result.fan_target   <= r_cur;
                r_result.load_percent <= '0;
            end
            r_result.target_written <= r_item.loop_active;
        end
    end

    assign o_result = r_result;
endmodule

`default_nettype wire

### rtl/load_tracking_fan_target_ramp.sv
`default_nettype none

// Channel   Direction  Handshake        Carries
// i_item    in         valid / ready    idle, kernel, user counters, flags, readback
// o_result  out        valid / ready    fan target, load percent, target written
// i_cfg_*   in         write enable     floor, ceiling, ramp limit (index 0..2)
//
// Once an item is accepted, the controller steps through a delta cycle, a
// scale cycle, eight restoring steps of the divider for the load, a cycle to
// finish the load, one to form the goal product, one to divide it by 100
// through a reciprocal multiply, and the update cycle, which makes the result
// valid. The input opens again only after the update cycle, so no new item is
// taken while one is in progress. Reset is synchronous and active low; it
// restores the register reset values and clears the stored counters and
// target. A stalled result holds the update cycle until the output register is free.
module load_tracking_fan_target_ramp (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    ltfr_in_if.sink                         i_item,
    ltfr_out_if.source                      o_result,
    input  wire logic                       i_cfg_we,
    input  wire logic [ltfr_pkg::IdxW-1:0]  i_cfg_idx,
    input  wire logic [ltfr_pkg::CfgW-1:0]  i_cfg_data
);
    import ltfr_pkg::*;

    t_cmd    cmd;
    t_item   item;
    t_result result;
    logic    in_ready;
    logic    out_valid;

    // Pack the incoming item for the datapath.
    always_comb begin
        item.idle_time       = i_item.idle_time;
        item.kernel_time     = i_item.kernel_time;
        item.user_time       = i_item.user_time;
        item.sample_valid    = i_item.sample_valid;
        item.target_readback = i_item.target_readback;
        item.reseed          = i_item.reseed;
        item.loop_active     = i_item.loop_active;
    end

    // The controller sequences one item at a time through the datapath.
    ltfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (cmd)
    );

    // The datapath holds configuration, the stored counters, the current
    // target, the load divider and the result register.
    ltfr_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_item     (item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_result   (result)
    );

    assign i_item.ready            = in_ready;
    assign o_result.valid          = out_valid;
    assign o_result.fan_target     = result.fan_target;
    assign o_result.load_percent   = result.load_percent;
    assign o_result.target_written = result.target_written;

    // An accepted item keeps the input closed for the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.valid && i_item.ready |=> !i_item.ready)
        else $error("input accepted while an item is in progress");

    // An inactive tick reports no load.
    a_idle_no_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && !o_result.target_written |-> o_result.load_percent == '0)
        else $error("load reported on an inactive tick");

    // Load never exceeds full scale.
    a_load_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> o_result.load_percent <= LoadW'(LoadFull))
        else $error("load above full scale");

    // A result that is not taken stays valid and unchanged.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && !o_result.ready |=> o_result.valid
            && $stable({o_result.fan_target, o_result.load_percent,
                        o_result.target_written}))
        else $error("waiting result changed or dropped");
endmodule

`default_nettype wire

### tb/sv/ltfr_target_checker.sv
module ltfr_target_checker
    import ltfr_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    ltfr_in_if                    i_item_mon,
    ltfr_out_if                   i_result_mon,
    input  wire logic             i_cfg_we,
    input  wire logic [IdxW-1:0]  i_cfg_idx,
    input  wire logic [CfgW-1:0]  i_cfg_data,
    output int                    o_mismatches,
    output int                    o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // Mirror of the block state and its limit registers.
    logic [CntW-1:0] prev_busy;
    logic [CntW-1:0] prev_idle;
    logic [TgtW-1:0] fan_level;
    logic [CfgW-1:0] tgt_floor;
    logic [CfgW-1:0] tgt_ceiling;
    logic [CfgW-1:0] ramp_step;

    t_result expected_fan_q[$];

    // Load in percent from the counter deltas; stores the counters for a valid sample.
    function automatic logic [LoadW-1:0] measure_load(input t_item tick);
        logic [CntW-1:0] busy;
        logic [CntW-1:0] d_busy;
        logic [CntW-1:0] d_idle;
        logic [127:0]    scaled;
        int unsigned     load;
        load = 0;
        if (!tick.sample_valid) begin
            return '0;
        end
        busy = tick.kernel_time + tick.user_time;
        if (prev_busy != '0 && busy > prev_busy) begin
            d_busy = busy - prev_busy;
            d_idle = (tick.idle_time > prev_idle) ? tick.idle_time - prev_idle : '0;
            if (d_idle < d_busy) begin
                scaled = (128'(d_idle) * 128'(LoadFull)) / 128'(d_busy);
                load   = LoadFull - int'(scaled[LoadW-1:0]);
            end
        end
        prev_busy = busy;
        prev_idle = tick.idle_time;
        return load[LoadW-1:0];
    endfunction

    function automatic t_result predict_fan_target(input t_item tick);
        t_result          res;
        logic [LoadW-1:0] load;
        int               lo;
        int               hi;
        int               step;
        int               goal;
        int               cur;
        int               diff;
        if (!tick.loop_active) begin
            res.fan_target     = fan_level;
            res.load_percent   = '0;
            res.target_written = 1'b0;
            return res;
        end
        if (tick.reseed) begin
            fan_level = '0;
        end
        load = measure_load(tick);
        lo   = int'(tgt_floor);
        hi   = int'(tgt_ceiling);
        step = int'(ramp_step);
        // Signed division truncates toward zero, which matters when the floor
        // lies above the ceiling.
        goal = lo + ((hi - lo) * int'(load)) / int'(LoadFull);
        cur  = int'(fan_level);
        if (cur == 0) begin
            cur = int'(tick.target_readback);
        end
        if (cur < lo) begin
            cur = lo;
        end
        diff = goal - cur;
        if (diff > step) begin
            diff = step;
        end
        if (diff < -step) begin
            diff = -step;
        end
        cur = cur + diff;
        if (cur < lo) begin
            cur = lo;
        end
        if (cur > hi) begin
            cur = hi;
        end
        fan_level          = cur[TgtW-1:0];
        res.fan_target     = fan_level;
        res.load_percent   = load;
        res.target_written = 1'b1;
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input t_result want, input t_result got);
        o_mismatches++;
        if (o_mismatches <= 10) begin
            $display("%0t: %s: expected target %0d load %0d written %0b, got target %0d load %0d written %0b",
                     $time, what, want.fan_target, want.load_percent, want.target_written,
                     got.fan_target, got.load_percent, got.target_written);
        end
    endtask

    always @(posedge i_clk) begin
        t_item   tick;
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            prev_busy   = '0;
            prev_idle   = '0;
            fan_level   = '0;
            tgt_floor   = FloorRst;
            tgt_ceiling = CeilingRst;
            ramp_step   = RampRst;
            expected_fan_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CfgFloor:   tgt_floor   = i_cfg_data;
                    CfgCeiling: tgt_ceiling = i_cfg_data;
                    CfgRamp:    ramp_step   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_result_mon.valid && i_result_mon.ready) begin
                got.fan_target     = i_result_mon.fan_target;
                got.load_percent   = i_result_mon.load_percent;
                got.target_written = i_result_mon.target_written;
                if (expected_fan_q.size() == 0) begin
                    flag_mismatch("result with no item pending", '0, got);
                end else begin
                    want = expected_fan_q.pop_front();
                    if (got.fan_target !== want.fan_target
                            || got.load_percent !== want.load_percent
                            || got.target_written !== want.target_written) begin
                        flag_mismatch("result mismatch", want, got);
                    end
                end
            end
            if (i_item_mon.valid && i_item_mon.ready) begin
                tick.idle_time       = i_item_mon.idle_time;
                tick.kernel_time     = i_item_mon.kernel_time;
                tick.user_time       = i_item_mon.user_time;
                tick.sample_valid    = i_item_mon.sample_valid;
                tick.target_readback = i_item_mon.target_readback;
                tick.reseed          = i_item_mon.reseed;
                tick.loop_active     = i_item_mon.loop_active;
                expected_fan_q.push_back(predict_fan_target(tick));
            end
        end
        o_outstanding = expected_fan_q.size();
    end

endmodule

### tb/sv/tb_load_tracking_fan_target_ramp.sv
module tb_load_tracking_fan_target_ramp;
    timeunit 1ns;
    timeprecision 1ps;

    import ltfr_pkg::*;

    // A run is stuck when no item moves on either channel for this many cycles.
    // The longest correct quiet stretch is the long receiver hold-off plus one
    // item of latency, so this leaves a wide margin.
    localparam int unsigned QuietLimit = 2000;
    // Length of the deliberate receiver hold-off that backs up the block.
    localparam int unsigned HoldCycles = 250;
    localparam int unsigned PhaseTicks = 50;
    localparam int unsigned NumPhases  = 8;

    logic            i_clk;
    logic            i_rst_n;
    logic            cfg_we;
    logic [IdxW-1:0] cfg_idx;
    logic [CfgW-1:0] cfg_data;

    int mismatches;
    int outstanding;

    // Idling controls shared between the stimulus and the receiver.
    bit gaps_on;
    bit stalls_on;
    bit hold_req;

    // Running counters from which well-formed samples are built.
    logic [CntW-1:0] run_idle;
    logic [CntW-1:0] run_kern;
    logic [CntW-1:0] run_user;

    ltfr_in_if  item_ch ();
    ltfr_out_if result_ch ();

    load_tracking_fan_target_ramp u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_ch),
        .o_result   (result_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // The checker watches both channels and the register port; it owns the
    // prediction and hands back only its failure count and open expectations.
    ltfr_target_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_mon    (item_ch),
        .i_result_mon  (result_ch),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result receiver. It stalls in short random bursts while stalls are
    // enabled, and once on request it holds off for a long stretch so that the
    // block fills up and has to stall its input while the sender keeps offering.
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HoldCycles;
            end else if (stall_left == 0 && stalls_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 7);
            end
            if (stall_left > 0) begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run if nothing is accepted on either side for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QuietLimit) begin
            @(posedge i_clk);
            if (!i_rst_n || (item_ch.valid && item_ch.ready)
                    || (result_ch.valid && result_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Verification failed");
        $finish;
    end

    // Offers one item and returns at the falling edge after it was accepted,
    // with valid still high. The caller either offers the next item at once or
    // lowers valid, so valid is never dropped and raised in the same step.
    task automatic send_tick(input t_item tick);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        item_ch.idle_time       <= tick.idle_time;
        item_ch.kernel_time     <= tick.kernel_time;
        item_ch.user_time       <= tick.user_time;
        item_ch.sample_valid    <= tick.sample_valid;
        item_ch.target_readback <= tick.target_readback;
        item_ch.reseed          <= tick.reseed;
        item_ch.loop_active     <= tick.loop_active;
        item_ch.valid           <= 1'b1;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic tick_with(input logic [CntW-1:0] idle, input logic [CntW-1:0] kern,
                             input logic [CntW-1:0] user, input bit valid,
                             input logic [TgtW-1:0] readback, input bit reseed,
                             input bit active);
        t_item tick;
        tick.idle_time       = idle;
        tick.kernel_time     = kern;
        tick.user_time       = user;
        tick.sample_valid    = valid;
        tick.target_readback = readback;
        tick.reseed          = reseed;
        tick.loop_active     = active;
        send_tick(tick);
    endtask

    // Stops offering and waits until every expected result has come back,
    // and keeps the clock running until the block is surely idle.
    task automatic drain_results;
        item_ch.valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Writes all three limit registers on consecutive cycles while the block is idle.
    task automatic program_limits(input logic [CfgW-1:0] lo, input logic [CfgW-1:0] hi,
                                  input logic [CfgW-1:0] step);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_idx  <= CfgFloor;
        cfg_data <= lo;
        @(negedge i_clk);
        cfg_idx  <= CfgCeiling;
        cfg_data <= hi;
        @(negedge i_clk);
        cfg_idx  <= CfgRamp;
        cfg_data <= step;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // Builds one random tick. Most ticks follow the running counters so that
    // the load takes meaningful values and the target ramps; the rest are pure
    // noise or broken samples where idle and busy stand still or run backwards.
    task automatic make_random_tick(output t_item tick);
        int unsigned     kind;
        logic [CntW-1:0] d_busy;
        logic [CntW-1:0] d_idle;
        logic [CntW-1:0] d_kern;
        kind = $urandom_range(0, 99);
        tick.sample_valid    = $urandom_range(0, 11) != 0;
        tick.target_readback = TgtW'($urandom_range(0, 255));
        tick.reseed          = $urandom_range(0, 15) == 0;
        tick.loop_active     = $urandom_range(0, 11) != 0;
        if (kind < 78) begin
            d_busy = ({$urandom, $urandom} >> $urandom_range(16, 63)) + CntW'(1);
            // Idle may exceed busy now and then, which forces a zero load; a
            // zero idle step gives full load.
            if ($urandom_range(0, 7) == 0) begin
                d_idle = '0;
            end else begin
                d_idle = {$urandom, $urandom} % (d_busy + (d_busy >> 3) + CntW'(1));
            end
            d_kern = {$urandom, $urandom} % (d_busy + CntW'(1));
            run_idle += d_idle;
            run_kern += d_kern;
            run_user += d_busy - d_kern;
            tick.idle_time   = run_idle;
            tick.kernel_time = run_kern;
            tick.user_time   = run_user;
        end else if (kind < 90) begin
            tick.idle_time   = {$urandom, $urandom};
            tick.kernel_time = {$urandom, $urandom};
            tick.user_time   = {$urandom, $urandom};
        end else begin
            tick.idle_time   = run_idle - CntW'($urandom_range(0, 1000));
            tick.kernel_time = run_kern - CntW'($urandom_range(0, 3));
            tick.user_time   = run_user;
        end
    endtask

    initial begin : stimulus
        t_item tick;

        // Every input of the block is known from time zero.
        i_rst_n                 = 1'b0;
        cfg_we                  = 1'b0;
        cfg_idx                 = CfgFloor;
        cfg_data                = '0;
        item_ch.valid           = 1'b0;
        item_ch.idle_time       = '0;
        item_ch.kernel_time     = '0;
        item_ch.user_time       = '0;
        item_ch.sample_valid    = 1'b0;
        item_ch.target_readback = '0;
        item_ch.reseed          = 1'b0;
        item_ch.loop_active     = 1'b0;
        gaps_on                 = 1'b1;
        stalls_on               = 1'b1;
        hold_req                = 1'b0;
        run_idle                = '0;
        run_kern                = '0;
        run_user                = '0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part with the reset limits (floor 80, ceiling 123, step 4).
        // An inactive tick right after reset reports the unseeded target of
        // zero and ignores its reseed flag.
        tick_with('0, '0, '0, 1'b1, 8'd200, 1'b1, 1'b0);
        // No earlier sample: load 0, and a low readback is raised to the floor.
        tick_with(64'd100, 64'd50, 64'd50, 1'b1, 8'd10, 1'b0, 1'b1);
        // Idle unchanged while busy grew: full load, the target ramps up.
        tick_with(64'd100, 64'd100, 64'd100, 1'b1, 8'd10, 1'b0, 1'b1);
        // Busy went down: load 0, but the counters are stored.
        tick_with(64'd100, 64'd75, 64'd75, 1'b1, 8'd10, 1'b0, 1'b1);
        // Idle went backwards: its delta counts as zero.
        tick_with(64'd50, 64'd150, 64'd150, 1'b1, 8'd10, 1'b0, 1'b1);
        // Idle grew more than busy: load 0.
        tick_with(64'd1050, 64'd200, 64'd200, 1'b1, 8'd10, 1'b0, 1'b1);
        // Invalid sample with extreme counters: load 0 and counters kept.
        tick_with('1, '1, '0, 1'b0, 8'd0, 1'b0, 1'b1);
        // Half load.
        tick_with(64'd1100, 64'd250, 64'd250, 1'b1, 8'd10, 1'b0, 1'b1);
        // Reseed from the top readback; the ceiling clamps it.
        tick_with(64'd1133, 64'd300, 64'd300, 1'b1, 8'd255, 1'b1, 1'b1);
        // Reseed on an inactive tick changes nothing.
        tick_with(64'd1133, 64'd300, 64'd300, 1'b1, 8'd0, 1'b1, 1'b0);
        // Reseed with a zero readback falls back to the floor.
        tick_with(64'd1133, 64'd300, 64'd300, 1'b1, 8'd0, 1'b1, 1'b1);
        // Deltas near the full counter width: the scaled product would not fit
        // in 64 bits.
        tick_with('1, '1, '1, 1'b1, 8'd37, 1'b0, 1'b1);
        // Busy wraps to zero, which also clears the earlier-sample history.
        tick_with('0, '1, 64'd1, 1'b1, 8'd37, 1'b0, 1'b1);
        tick_with(64'd10, 64'd20, 64'd20, 1'b1, 8'd37, 1'b0, 1'b1);
        tick_with(64'h4000_0000_0000_000A, 64'h4000_0000_0000_0000,
                  64'h4000_0000_0000_0000, 1'b1, 8'd37, 1'b0, 1'b1);

        // Floor above the ceiling: the goal uses a negative span and the
        // ceiling wins the final clamp.
        program_limits(8'd200, 8'd50, 8'd7);
        tick_with(64'h4000_0000_0000_000A, 64'h4000_0000_0000_0000,
                  64'h4000_0000_0000_0000, 1'b1, 8'd90, 1'b0, 1'b1);
        tick_with(64'h4000_0000_0000_000A, 64'h4000_0000_0000_0064,
                  64'h4000_0000_0000_0000, 1'b1, 8'd90, 1'b0, 1'b1);

        // Widest limits with an unbounded step: full load jumps straight to the
        // top, and no load drops straight to zero.
        program_limits(8'd0, 8'd255, 8'd255);
        tick_with(64'h4000_0000_0000_000A, 64'h4000_0000_0000_00C8,
                  64'h4000_0000_0000_0000, 1'b1, 8'd0, 1'b1, 1'b1);
        tick_with(64'h4000_0000_0000_006E, 64'h4000_0000_0000_012C,
                  64'h4000_0000_0000_0000, 1'b1, 8'd0, 1'b0, 1'b1);
        tick_with(64'h4000_0000_0000_006E, 64'h4000_0000_0000_0190,
                  64'h4000_0000_0000_0000, 1'b1, 8'd0, 1'b0, 1'b1);

        // Random phases, each under its own limits. The last phase runs with no
        // idling on either side.
        for (int ph = 0; ph < NumPhases; ph++) begin
            case (ph)
                0: program_limits(8'd80, 8'd123, 8'd4);
                1: program_limits(8'd0, 8'd255, 8'd255);
                2: program_limits(8'd200, 8'd50, 8'd7);
                3: program_limits(8'd255, 8'd255, 8'd0);
                4: program_limits(8'd0, 8'd0, 8'd1);
                7: program_limits(8'd60, 8'd180, 8'd3);
                default: program_limits(CfgW'($urandom_range(0, 255)),
                                        CfgW'($urandom_range(0, 255)),
                                        CfgW'($urandom_range(0, 255)));
            endcase
            if (ph == NumPhases - 1) begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end else if (ph == 5) begin
                // A stretch with idling switched off in the middle of the run.
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end else begin
                gaps_on   = 1'b1;
                stalls_on = 1'b1;
            end
            // Start each phase from fresh counters so high counter bits and
            // wrapping busy sums come up.
            run_idle = {$urandom, $urandom};
            run_kern = {$urandom, $urandom};
            run_user = {$urandom, $urandom};
            for (int n = 0; n < PhaseTicks; n++) begin
                if (ph == 2 && n == 10) begin
                    hold_req = 1'b1;
                end
                make_random_tick(tick);
                send_tick(tick);
            end
        end

        // Wait for every outstanding result, then keep the clock running in case
        // the block produces something it should not.
        item_ch.valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/ltfr_pkg.sv
rtl/ltfr_in_if.sv
rtl/ltfr_out_if.sv
rtl/ltfr_ctrl.sv
rtl/ltfr_dp.sv
rtl/load_tracking_fan_target_ramp.sv
tb/sv/ltfr_target_checker.sv
tb/sv/tb_load_tracking_fan_target_ramp.sv
